[sv/tpmsc_pkg.sv]
// ----------------------------------------------------------------------------
// tpmsc_pkg
// Shared types and constants for the tachometer PID speed controller.
// ----------------------------------------------------------------------------
package tpmsc_pkg;

    localparam logic [1:0] CMD_EDGE_ONE = 2'd0;
    localparam logic [1:0] CMD_EDGE_TWO = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic [1:0] REG_GAIN_P   = 2'd0;
    localparam logic [1:0] REG_GAIN_I   = 2'd1;
    localparam logic [1:0] REG_GAIN_D   = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic signed [33:0] ERROR_DIV = 34'sd100;
    localparam logic signed [65:0] OUT_DIV   = 66'sd10;
    localparam logic signed [65:0] DRIVE_MAX = 66'sd999;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] edge_time;
        logic [30:0] target_speed;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  drive_level;
        logic [30:0] measured_speed;
        logic        no_interval;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

[sv/tpmsc_if.sv]
// ----------------------------------------------------------------------------
// tpmsc_in_if / tpmsc_out_if / tpmsc_cfg_if
// Valid/ready channels carrying items of the speed controller.
// ----------------------------------------------------------------------------
interface tpmsc_in_if;
    logic                 valid;
    logic                 ready;
    tpmsc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpmsc_out_if;
    logic                 valid;
    logic                 ready;
    tpmsc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpmsc_cfg_if;
    logic                 valid;
    logic                 ready;
    tpmsc_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/tachometer_pid_motor_speed_control.sv]
// ----------------------------------------------------------------------------
// tachometer_pid_motor_speed_control
// Encoder period measurement and PID speed loop driving a PWM duty level.
// ----------------------------------------------------------------------------
// An edge item is a ring read, then a ring and sum update. A control tick
// runs the mean, the speed quotient and the error over 100 through one
// shared bit-serial 32-bit divider at one bit a cycle, followed by three
// serial gain products (one gain bit a cycle) and the final division by
// ten. A zero mean skips the speed quotient and a total that clamps skips
// the division by ten. Items are handled one at a time; the result sits in
// an output register and a new item is taken while it waits. A tick that
// finishes while the previous result still waits holds in its last step
// until the output register frees. Reset clears the interval ring entry by
// entry, during which no item is taken; configuration writes are taken at
// any time.
// ----------------------------------------------------------------------------
module tachometer_pid_motor_speed_control #(
    parameter int unsigned RING_DEPTH = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tpmsc_in_if.sink    in_ch,
    tpmsc_out_if.source out_ch,
    tpmsc_cfg_if.sink   cfg_ch
);
    localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_EDGE  = 16'h0004,
        S_MEAN  = 16'h0008,
        S_SPEED = 16'h0010,
        S_ERR   = 16'h0020,
        S_MULP  = 16'h0040,
        S_MULI  = 16'h0080,
        S_MULD  = 16'h0100,
        S_OUTD  = 16'h0200,
        S_OUT   = 16'h0400,
        S_WAITD = 16'h0800,
        S_SIGN  = 16'h1000,
        S_INTG  = 16'h2000,
        S_SUM   = 16'h4000,
        S_FIN   = 16'h8000
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [30:0] r_scale;

    // measurement state
    logic [31:0]   r_ring [RING_DEPTH];
    logic [31:0]   r_ring_rd;
    logic [PW-1:0] r_pos, r_clr;
    logic [31:0]   r_sum, r_t1, r_t2, r_span;
    logic          r_last;
    logic signed [31:0] r_integ, r_prev;

    // tick working registers
    tpmsc_pkg::t_in_item r_item;
    logic [30:0]  r_speed;
    logic         r_flag;
    logic signed [33:0] r_e;
    logic signed [33:0] r_acc;
    logic signed [65:0] r_ctl;
    logic signed [65:0] r_mcand;
    logic [15:0]  r_mplier;
    logic [4:0]   r_mcnt;
    logic         r_neg;
    tpmsc_pkg::t_out_item r_out;
    logic         r_out_v;

    // shared divider
    logic        w_div_start, w_div_done;
    logic [31:0] w_div_num, w_div_den, w_div_q;
    logic [31:0] r_div_num, r_div_den;

    tpmsc_serdiv #(.W(32)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    logic r_div_go;
    logic w_div_go;
    assign w_div_start = r_div_go;
    assign w_div_num   = r_div_num;
    assign w_div_den   = r_div_den;

    logic w_in_acc;
    logic w_out_free;
    assign in_ch.ready  = (r_state == S_IDLE);
    assign w_in_acc     = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_v;
    assign out_ch.data  = r_out;
    // output register can take a new result this cycle
    assign w_out_free   = !r_out_v || out_ch.ready;

    logic        w_other;
    logic [31:0] w_err_mag;
    logic signed [32:0] w_raw;
    assign w_raw = $signed({2'b0, r_item.target_speed}) - $signed({2'b0, r_speed});

    // kick the divider whenever a step hands it new operands
    assign w_div_go = (w_in_acc && in_ch.data.cmd == tpmsc_pkg::CMD_TICK)
                   || (r_state == S_MEAN && w_div_done && w_div_q != 32'd0)
                   || (r_state == S_ERR)
                   || (r_state == S_SIGN && r_ctl >= 66'sd0 && r_ctl < 66'sd10000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= w_div_go;
        end
    end

    // configuration writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= 16'd10;
            r_gain_i <= 16'd1;
            r_gain_d <= 16'd0;
            r_scale  <= 31'd360000000;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data.index)
                3'(tpmsc_pkg::REG_GAIN_P): r_gain_p <= cfg_ch.data.data[15:0];
                3'(tpmsc_pkg::REG_GAIN_I): r_gain_i <= cfg_ch.data.data[15:0];
                3'(tpmsc_pkg::REG_GAIN_D): r_gain_d <= cfg_ch.data.data[15:0];
                3'(tpmsc_pkg::REG_SCALE):  r_scale  <= cfg_ch.data.data[30:0];
                default: ;
            endcase
        end
    end

    // ring memory: one write port, registered read
    logic          w_ring_we;
    logic [PW-1:0] w_ring_wa;
    logic [31:0]   w_ring_wd;
    assign w_ring_we = (r_state == S_CLEAR) || (r_state == S_EDGE && w_other);
    assign w_ring_wa = (r_state == S_CLEAR) ? r_clr : r_pos;
    assign w_ring_wd = (r_state == S_CLEAR) ? 32'd0 : r_span;
    always_ff @(posedge i_clk) begin
        if (w_ring_we) r_ring[w_ring_wa] <= w_ring_wd;
        r_ring_rd <= r_ring[r_pos];
    end

    assign w_other = (r_item.cmd == tpmsc_pkg::CMD_EDGE_ONE) ? r_last : !r_last;
    assign w_err_mag = w_raw[32] ? 32'(-w_raw) : 32'(w_raw);

    // saturating integral sum
    logic signed [33:0] w_acc_raw;
    assign w_acc_raw = 34'(r_integ) + r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_t1    <= '0;
            r_t2    <= '0;
            r_last  <= 1'b0;
            r_integ <= '0;
            r_prev  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) r_out_v <= 1'b1;
            else if (out_ch.valid && out_ch.ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PW'(RING_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_item <= in_ch.data;
                        case (in_ch.data.cmd)
                            tpmsc_pkg::CMD_EDGE_ONE: begin
                                r_span  <= in_ch.data.edge_time - r_t2;
                                r_state <= S_EDGE;
                            end
                            tpmsc_pkg::CMD_EDGE_TWO: begin
                                r_span  <= in_ch.data.edge_time - r_t1;
                                r_state <= S_EDGE;
                            end
                            tpmsc_pkg::CMD_TICK: begin
                                r_div_num <= r_sum;
                                r_div_den <= 32'(RING_DEPTH);
                                r_state   <= S_MEAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EDGE: begin
                    if (w_other) begin
                        r_sum <= r_sum - r_ring_rd + r_span;
                        r_pos <= (r_pos == PW'(RING_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                    end
                    if (r_item.cmd == tpmsc_pkg::CMD_EDGE_ONE) begin
                        r_t1   <= r_item.edge_time;
                        r_last <= 1'b0;
                    end else begin
                        r_t2   <= r_item.edge_time;
                        r_last <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_MEAN: begin
                    if (w_div_done) begin
                        if (w_div_q == 32'd0) begin
                            r_speed <= '0;
                            r_flag  <= 1'b1;
                            r_state <= S_ERR;
                        end else begin
                            r_flag    <= 1'b0;
                            r_div_num <= {1'b0, r_scale};
                            r_div_den <= w_div_q;
                            r_state   <= S_SPEED;
                        end
                    end
                end
                S_SPEED: begin
                    if (w_div_done) begin
                        r_speed <= w_div_q[30:0];
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    // magnitude of error over 100, sign restored afterwards
                    r_neg     <= w_raw[32];
                    r_div_num <= w_err_mag;
                    r_div_den <= 32'(tpmsc_pkg::ERROR_DIV);
                    r_state   <= S_WAITD;
                end
                S_WAITD: begin
                    if (w_div_done) begin
                        r_e <= r_neg ? -34'(w_div_q) : 34'(w_div_q);
                        r_state <= S_INTG;
                    end
                end
                S_INTG: begin
                    if (w_acc_raw > 34'sd2147483647) r_acc <= 34'sd2147483647;
                    else if (w_acc_raw < -34'sd2147483648) r_acc <= -34'sd2147483648;
                    else r_acc <= w_acc_raw;
                    r_ctl    <= '0;
                    r_mcand  <= 66'(r_e);
                    r_mplier <= r_gain_p;
                    r_mcnt   <= 5'd16;
                    r_state  <= S_MULP;
                end
                S_MULP, S_MULI, S_MULD: begin
                    // shift-add: one gain bit a cycle
                    if (r_mcnt != 5'd0) begin
                        if (r_mplier[0]) r_ctl <= r_ctl + r_mcand;
                        r_mcand  <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_mcnt   <= r_mcnt - 1'b1;
                    end else begin
                        r_mcnt <= 5'd16;
                        if (r_state == S_MULP) begin
                            r_mcand  <= 66'(r_acc);
                            r_mplier <= r_gain_i;
                            r_state  <= S_MULI;
                        end else if (r_state == S_MULI) begin
                            r_mcand  <= 66'(r_e) - 66'(r_prev);
                            r_mplier <= r_gain_d;
                            r_state  <= S_MULD;
                        end else begin
                            r_integ <= 32'(r_acc);
                            r_prev  <= 32'(r_e);
                            r_state <= S_SIGN;
                        end
                    end
                end
                S_SIGN: begin
                    // negative totals clamp to zero; so division sign is moot
                    if (r_ctl < 0) begin
                        r_ctl   <= '0;
                        r_state <= S_FIN;
                    end else if (r_ctl >= 66'sd10000) begin
                        r_ctl   <= tpmsc_pkg::DRIVE_MAX;
                        r_state <= S_FIN;
                    end else begin
                        r_div_num <= 32'(r_ctl);
                        r_div_den <= 32'(tpmsc_pkg::OUT_DIV);
                        r_state   <= S_OUTD;
                    end
                end
                S_OUTD: begin
                    if (w_div_done) begin
                        r_ctl   <= 66'(w_div_q);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the previous result has left
                    if (w_out_free) begin
                        r_out.drive_level    <= 10'(r_ctl);
                        r_out.measured_speed <= r_speed;
                        r_out.no_interval    <= r_flag;
                        r_state <= S_IDLE;
                    end
                end
                S_SUM, S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result changed while waiting");
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.drive_level <= 10'd999)) else $error("drive out of range");
    a_flag_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.no_interval) |-> (r_out.measured_speed == '0))
        else $error("flag with nonzero speed");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(RING_DEPTH - 1)) else $error("ring pointer out of range");
endmodule

[sv/tpmsc_serdiv.sv]
// ----------------------------------------------------------------------------
// tpmsc_serdiv
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpmsc_serdiv #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, n_quot;
    logic [W-1:0]  r_rem,  n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_quot[W-1]} - {1'b0, r_den};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one numerator bit in, subtract when it fits
            if (!w_trial[W]) begin
                n_rem  = w_trial[W-1:0];
                n_quot = {r_quot[W-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[W-2:0], r_quot[W-1]};
                n_quot = {r_quot[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tachometer PID speed controller. Drives encoder
// edges, control ticks and unused codes through the input channel, predicts
// every result with a behavioural model of the ring, divider and PID loop,
// and checks each result item field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING_LEN  = 12;
    localparam logic [1:0]  CMD_SPARE = 2'd3;
    localparam logic [30:0] TGT_MAX   = 31'h7FFF_FFFF;

    // Random phase flavours: mixed targets, integral driven up, driven down.
    localparam int MIX_RUN = 0;
    localparam int SAT_UP  = 1;
    localparam int SAT_DN  = 2;

    logic i_clk;
    logic i_rst_n;

    tpmsc_in_if  in_bus ();
    tpmsc_out_if out_bus ();
    tpmsc_cfg_if cfg_bus ();

    tachometer_pid_motor_speed_control i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .cfg_ch  (cfg_bus)
    );

    // ------------------------------------------------------------------------
    // Speed controller model: configuration and measurement state.
    // ------------------------------------------------------------------------
    logic [15:0]        kp, ki, kd;
    logic [30:0]        scale;
    logic [31:0]        span_ring [RING_LEN];
    int unsigned        ring_pos;
    logic [31:0]        span_total;
    logic               last_chan_two;
    logic [31:0]        time_one, time_two;
    int signed          err_acc;
    int signed          err_last;

    tpmsc_pkg::t_out_item pending_speed_q [$];
    int                   mismatches;

    // Push an interval into the ring and keep the running total in step.
    function automatic void push_span(logic [31:0] span);
        span_total          = span_total - span_ring[ring_pos] + span;
        span_ring[ring_pos] = span;
        ring_pos            = (ring_pos + 1) % RING_LEN;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            3'(tpmsc_pkg::REG_GAIN_P): kp    = val[15:0];
            3'(tpmsc_pkg::REG_GAIN_I): ki    = val[15:0];
            3'(tpmsc_pkg::REG_GAIN_D): kd    = val[15:0];
            3'(tpmsc_pkg::REG_SCALE):  scale = val[30:0];
            default: ;
        endcase
    endfunction

    // Advance the model by one item; return 1 with the result on a tick.
    function automatic bit model_item(tpmsc_pkg::t_in_item it,
                                      output tpmsc_pkg::t_out_item res);
        logic [31:0]    mean;
        logic [31:0]    speed;
        longint signed  err, acc, deriv, ctl;

        res = '0;
        case (it.cmd)
            tpmsc_pkg::CMD_EDGE_ONE: begin
                time_one = it.edge_time;
                if (last_chan_two)
                    push_span(it.edge_time - time_two);
                last_chan_two = 1'b0;
                return 1'b0;
            end
            tpmsc_pkg::CMD_EDGE_TWO: begin
                time_two = it.edge_time;
                if (!last_chan_two)
                    push_span(it.edge_time - time_one);
                last_chan_two = 1'b1;
                return 1'b0;
            end
            tpmsc_pkg::CMD_TICK: begin
                mean  = span_total / RING_LEN;
                speed = (mean == 0) ? 32'd0 : {1'b0, scale} / mean;
                err   = (longint'({1'b0, it.target_speed}) - longint'(speed)) / 100;
                acc   = longint'(err_acc) + err;
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                err_acc  = int'(acc);
                deriv    = err - longint'(err_last);
                err_last = int'(err);
                ctl = err * longint'({1'b0, kp}) + acc * longint'({1'b0, ki})
                    + deriv * longint'({1'b0, kd});
                ctl = ctl / 10;
                if (ctl > 999)
                    ctl = 999;
                if (ctl < 0)
                    ctl = 0;
                res.drive_level    = ctl[9:0];
                res.measured_speed = speed[30:0];
                res.no_interval    = (mean == 0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and time limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern, one long hold-off, and the checker.
    // ------------------------------------------------------------------------
    bit hold_req;
    bit hold_done;

    initial begin
        int hold_cnt;
        int mode;
        int mode_left;
        out_bus.ready = 1'b0;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                // Starve the output long enough for the input side to back up.
                out_bus.ready = 1'b0;
                hold_cnt++;
                if (hold_cnt >= 3000)
                    hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0: out_bus.ready = 1'b1;
                    1: out_bus.ready = 1'($urandom_range(0, 1));
                    default: out_bus.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        tpmsc_pkg::t_out_item want;
        tpmsc_pkg::t_out_item got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = out_bus.data;
            if (pending_speed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: drive %0d speed %0d flag %0d",
                             got.drive_level, got.measured_speed, got.no_interval);
            end else begin
                want = pending_speed_q.pop_front();
                if (got.drive_level !== want.drive_level
                        || got.measured_speed !== want.measured_speed
                        || got.no_interval !== want.no_interval) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp drive %0d speed %0d flag %0d, got %0d %0d %0d",
                                 want.drive_level, want.measured_speed, want.no_interval,
                                 got.drive_level, got.measured_speed, got.no_interval);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side: bursty sender.
    // ------------------------------------------------------------------------
    int burst_left;

    // Offer one item, hold it until taken, then advance the model.
    // A typed expectation, where given, replaces the modelled one.
    task automatic send_item(tpmsc_pkg::t_in_item it, bit typed,
                             tpmsc_pkg::t_out_item typed_res);
        tpmsc_pkg::t_out_item res;
        int gap;
        @(negedge i_clk);
        in_bus.valid = 1'b1;
        in_bus.data  = it;
        do @(posedge i_clk); while (!in_bus.ready);
        if (model_item(it, res))
            pending_speed_q.push_back(typed ? typed_res : res);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                @(negedge i_clk);
                in_bus.valid = 1'b0;
                in_bus.data  = tpmsc_pkg::t_in_item'({$urandom, $urandom, $urandom});
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_bus.valid      = 1'b1;
        cfg_bus.data.index = idx;
        cfg_bus.data.data  = val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Drop the offer, hold until every result is in, let a trailing edge settle.
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        wait (pending_speed_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Random phase: mostly alternating edges with a realistic period, ticks
    // in between, plus repeated edges and the unused code as noise.
    // ------------------------------------------------------------------------
    logic [31:0] gen_time;
    bit          gen_two;

    task automatic random_phase(int count, int flavour);
        tpmsc_pkg::t_in_item it;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            it   = tpmsc_pkg::t_in_item'({$urandom, $urandom, $urandom});
            if (pick < 3) begin
                it.cmd = CMD_SPARE;
            end else if (pick < 9) begin
                // Same channel again: refresh its time, no interval stored.
                gen_time    += $urandom_range(0, 300);
                it.cmd       = gen_two ? tpmsc_pkg::CMD_EDGE_TWO : tpmsc_pkg::CMD_EDGE_ONE;
                it.edge_time = gen_time;
            end else if (pick < 30) begin
                it.cmd = tpmsc_pkg::CMD_TICK;
                case (flavour)
                    SAT_UP: it.target_speed = 31'(TGT_MAX - $urandom_range(0, 1000));
                    SAT_DN: it.target_speed = 31'($urandom_range(0, 3));
                    default:
                        if ($urandom_range(0, 1))
                            it.target_speed = 31'($urandom_range(0, 200000));
                endcase
            end else begin
                case (flavour)
                    SAT_UP: gen_time += $urandom;
                    SAT_DN: gen_time += $urandom_range(1, 3);
                    default: begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                            gen_time += $urandom_range(1, 5000);
                        else if (pick < 8)
                            gen_time += $urandom_range(0, 3);
                        else
                            gen_time += $urandom;
                    end
                endcase
                gen_two      = ~gen_two;
                it.cmd       = gen_two ? tpmsc_pkg::CMD_EDGE_TWO : tpmsc_pkg::CMD_EDGE_ONE;
                it.edge_time = gen_time;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Typed results only where they follow at a glance.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [1:0]           cmd;
        logic [31:0]          edge_time;
        logic [30:0]          target;
        bit                   typed;
        tpmsc_pkg::t_out_item res;
    } t_row;

    t_row script [] = '{
        // Empty ring: zero mean, speed forced to zero, flag raised.
        '{tpmsc_pkg::CMD_TICK,     32'h0,         31'd0,   1'b1, '{10'd0,   31'd0, 1'b1}},
        // Largest target on an empty ring: drive clamps at the top.
        '{tpmsc_pkg::CMD_TICK,     32'hFFFF_FFFF, TGT_MAX, 1'b1, '{10'd999, 31'd0, 1'b1}},
        '{CMD_SPARE,               32'hFFFF_FFFF, TGT_MAX, 1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_TWO, 32'd1000,      31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_TWO, 32'd1500,      31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_ONE, 32'd2000,      31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_TICK,     32'h0,         31'd5,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_ONE, 32'hFFFF_FFFF, 31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        // Timestamp wrap, then intervals large enough to wrap the total.
        '{tpmsc_pkg::CMD_EDGE_TWO, 32'h10,        31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_ONE, 32'h0,         31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_TWO, 32'hFFFF_FFFF, 31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_TICK,     32'h0,         31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_TICK,     32'h0,         TGT_MAX, 1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_ONE, 32'h5,         31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_EDGE_TWO, 32'h5,         31'd0,   1'b0, '{10'd0,   31'd0, 1'b0}},
        '{tpmsc_pkg::CMD_TICK,     32'h0,         31'd1,   1'b0, '{10'd0,   31'd0, 1'b0}}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        tpmsc_pkg::t_in_item it;

        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        mismatches    = 0;
        burst_left    = 8;
        gen_time      = 32'd0;
        gen_two       = 1'b0;

        kp = 16'd10;
        ki = 16'd1;
        kd = 16'd0;
        scale = 31'd360000000;
        foreach (span_ring[k])
            span_ring[k] = '0;
        ring_pos      = 0;
        span_total    = '0;
        last_chan_two = 1'b0;
        time_one      = '0;
        time_two      = '0;
        err_acc       = 0;
        err_last      = 0;

        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings first.
        foreach (script[r]) begin
            it.cmd          = script[r].cmd;
            it.edge_time    = script[r].edge_time;
            it.target_speed = script[r].target;
            send_item(it, script[r].typed, script[r].res);
        end
        // Starve the output while items keep coming in.
        hold_req = 1'b1;
        random_phase(250, MIX_RUN);
        drain();

        // Every register at its top; upper data bits are don't-care.
        write_reg(3'(tpmsc_pkg::REG_GAIN_P), 32'hFFFF_FFFF);
        write_reg(3'(tpmsc_pkg::REG_GAIN_I), 32'h0000_FFFF);
        write_reg(3'(tpmsc_pkg::REG_GAIN_D), 32'h0000_FFFF);
        write_reg(3'(tpmsc_pkg::REG_SCALE),  32'hFFFF_FFFF);
        random_phase(300, SAT_UP);
        drain();

        // Fast motor and zero targets: pull the integral to its floor.
        write_reg(3'(tpmsc_pkg::REG_GAIN_P), 32'd1);
        write_reg(3'(tpmsc_pkg::REG_GAIN_I), 32'd1);
        write_reg(3'(tpmsc_pkg::REG_GAIN_D), 32'd3);
        random_phase(250, SAT_DN);
        drain();

        // Bottom of every range.
        write_reg(3'(tpmsc_pkg::REG_GAIN_P), 32'hFFFF_0000);
        write_reg(3'(tpmsc_pkg::REG_GAIN_I), 32'd0);
        write_reg(3'(tpmsc_pkg::REG_GAIN_D), 32'd0);
        write_reg(3'(tpmsc_pkg::REG_SCALE),  32'h8000_0001);
        random_phase(250, MIX_RUN);
        drain();

        write_reg(3'(tpmsc_pkg::REG_GAIN_P), $urandom);
        write_reg(3'(tpmsc_pkg::REG_GAIN_I), $urandom_range(0, 64));
        write_reg(3'(tpmsc_pkg::REG_GAIN_D), $urandom);
        write_reg(3'(tpmsc_pkg::REG_SCALE),  $urandom);
        random_phase(350, MIX_RUN);

        @(negedge i_clk);
        in_bus.valid = 1'b0;
        wait (pending_speed_q.size() == 0);
        repeat (200) @(posedge i_clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
